// ===== hdl/radio_frame_deserializer_macros.svh =====
// Assertion helpers shared by the frame deserializer modules.
// Every module that uses them has ports named clock and reset.
`ifndef RADIO_FRAME_DESERIALIZER_MACROS_SVH
`define RADIO_FRAME_DESERIALIZER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RFD_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RFD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/rfd_pkg.sv =====
package rfd_pkg;

   // Frame classes held by the parser; CLS_NONE marks an unknown type byte.
   localparam logic [2:0] CLS_DATA = 3'd0;
   localparam logic [2:0] CLS_ACK  = 3'd1;
   localparam logic [2:0] CLS_POLL = 3'd2;
   localparam logic [2:0] CLS_PRES = 3'd3;
   localparam logic [2:0] CLS_NONE = 3'd4;

   localparam logic [1:0] KIND_SRC     = 2'd0;
   localparam logic [1:0] KIND_DST     = 2'd1;
   localparam logic [1:0] KIND_PAYLOAD = 2'd2;
   localparam logic [1:0] KIND_VERDICT = 2'd3;

   localparam logic [3:0] ERR_OK        = 4'd0;
   localparam logic [3:0] ERR_SHORT     = 4'd1;
   localparam logic [3:0] ERR_TYPE      = 4'd2;
   localparam logic [3:0] ERR_LENGTH    = 4'd3;
   localparam logic [3:0] ERR_EVENT     = 4'd4;
   localparam logic [3:0] ERR_SRC       = 4'd5;
   localparam logic [3:0] ERR_DST       = 4'd6;
   localparam logic [3:0] ERR_OVERSIZE  = 4'd7;
   localparam logic [3:0] ERR_TRUNCATED = 4'd8;

   localparam int CSR_INDEX_W = 3;
   localparam logic [CSR_INDEX_W-1:0] REG_CODE_DATA     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_CODE_ACK      = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_CODE_POLL     = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_CODE_PRESENCE = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_EVENT_ATTACH  = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_EVENT_DETACH  = 3'd5;

   localparam logic [7:0] PAYLOAD_LIMIT = 8'd200;

   // Byte offsets within a frame.
   localparam int OFF_W = 10;
   localparam logic [OFF_W-1:0] OFF_MSG       = 10'd1;
   localparam logic [OFF_W-1:0] OFF_ACK       = 10'd2;
   localparam logic [OFF_W-1:0] OFF_NODE      = 10'd3;
   localparam logic [OFF_W-1:0] OFF_HOP       = 10'd4;
   localparam logic [OFF_W-1:0] OFF_SRC_FIRST = 10'd5;
   localparam logic [OFF_W-1:0] OFF_SRC_END   = 10'd20;
   localparam logic [OFF_W-1:0] OFF_DST_FIRST = 10'd21;
   localparam logic [OFF_W-1:0] OFF_DST_END   = 10'd36;
   localparam logic [OFF_W-1:0] OFF_PRES_LEN  = 10'd21;
   localparam logic [OFF_W-1:0] OFF_EVENT     = 10'd22;
   localparam logic [OFF_W-1:0] OFF_LENGTH    = 10'd37;
   localparam logic [OFF_W-1:0] OFF_PAYLOAD   = 10'd38;
   localparam logic [OFF_W-1:0] OFF_MAX       = 10'd1023;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [1:0] result_kind;
      logic [7:0] data_byte;
      logic       frame_ok;
      logic [3:0] error_code;
      logic [1:0] packet_class;
      logic [7:0] message_id;
      logic [7:0] acked_id;
      logic [7:0] node_number;
      logic [7:0] hop_limit;
      logic [7:0] payload_length;
      logic [7:0] event_code;
   } rfd_rsp_type;

   // One parsed byte: an optional streamed beat and an optional verdict beat.
   typedef struct packed {
      logic        has_data;
      logic [1:0]  data_kind;
      logic [7:0]  data_byte;
      logic        has_verdict;
      rfd_rsp_type verdict;
   } rfd_op_type;

   // Id check bits: 0 non-empty, 1 terminator seen, 2 non-digit seen.
   function automatic logic [2:0] id_update(input logic [2:0] chk, input logic first,
                                            input logic [7:0] b);
      logic [2:0] res;
      res = chk;
      if (!chk[1]) begin
         if (b == 8'd0) begin
            res[1] = 1'b1;
         end else begin
            if (b < 8'h30 || b > 8'h39) res[2] = 1'b1;
            if (first) res[0] = 1'b1;
         end
      end
      return res;
   endfunction

   function automatic logic id_ok(input logic [2:0] chk);
      return chk[0] && !chk[2];
   endfunction

endpackage

// ===== hdl/rfd_front.sv =====
module rfd_front
   import rfd_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  logic [7:0]             byte_value,
   input  logic                   frame_end,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [7:0]             csr_wdata,
   output logic                   op_valid,
   output rfd_op_type             op
);

   logic [7:0] code_data_ff, code_ack_ff, code_poll_ff, code_presence_ff;
   logic [7:0] event_attach_ff, event_detach_ff;

   logic [OFF_W-1:0] off_ff, off_in;
   logic [2:0]       class_ff, cls;
   logic [7:0]       msg_ff, ack_ff, node_ff, hop_ff, pl_ff, event_ff;
   logic [7:0]       msg_in, ack_in, node_in, hop_in, pl_in, event_in;
   logic [2:0]       src_ff, dst_ff, src_in, dst_in;
   logic [7:0]       pl_base;
   logic [2:0]       src_base, dst_base;
   logic             first, is_dp, known;
   logic             src_stream, dst_stream, payload_stream, event_stream;
   logic [3:0]       err;

   always_comb begin
      first = (off_ff == '0);
      if (!first) cls = class_ff;
      else if (byte_value == code_data_ff) cls = CLS_DATA;
      else if (byte_value == code_ack_ff) cls = CLS_ACK;
      else if (byte_value == code_poll_ff) cls = CLS_POLL;
      else if (byte_value == code_presence_ff) cls = CLS_PRES;
      else cls = CLS_NONE;

      // A new frame starts from cleared header fields.
      msg_in   = (off_ff == OFF_MSG)  ? byte_value : (first ? 8'd0 : msg_ff);
      ack_in   = (off_ff == OFF_ACK)  ? byte_value : (first ? 8'd0 : ack_ff);
      node_in  = (off_ff == OFF_NODE) ? byte_value : (first ? 8'd0 : node_ff);
      hop_in   = (off_ff == OFF_HOP)  ? byte_value : (first ? 8'd0 : hop_ff);
      pl_base  = first ? 8'd0 : pl_ff;
      src_base = first ? 3'd0 : src_ff;
      dst_base = first ? 3'd0 : dst_ff;
      event_in = first ? 8'd0 : event_ff;

      is_dp = (cls == CLS_DATA) || (cls == CLS_POLL);
      known = (cls != CLS_NONE);

      src_stream = (is_dp || cls == CLS_PRES) && off_ff >= OFF_SRC_FIRST
                   && off_ff < OFF_SRC_END;
      dst_stream = is_dp && off_ff >= OFF_DST_FIRST && off_ff < OFF_DST_END;
      payload_stream = is_dp && off_ff >= OFF_PAYLOAD && pl_base <= PAYLOAD_LIMIT
                       && off_ff < OFF_PAYLOAD + {2'b00, pl_base};
      event_stream = (cls == CLS_PRES) && off_ff == OFF_EVENT;

      src_in = src_stream ? id_update(src_base, off_ff == OFF_SRC_FIRST, byte_value)
                          : src_base;
      dst_in = dst_stream ? id_update(dst_base, off_ff == OFF_DST_FIRST, byte_value)
                          : dst_base;
      pl_in = pl_base;
      if ((is_dp && off_ff == OFF_LENGTH) || (cls == CLS_PRES && off_ff == OFF_PRES_LEN))
         pl_in = byte_value;
      if (event_stream) event_in = byte_value;

      if (frame_end) off_in = '0;
      else if (off_ff == OFF_MAX) off_in = off_ff;
      else off_in = off_ff + 10'd1;

      // Verdict checks in priority order; the frame length is off_ff + 1.
      err = ERR_OK;
      if (off_ff < OFF_NODE) err = ERR_SHORT;
      else if (!known) err = ERR_TYPE;
      else if (cls == CLS_ACK) err = ERR_OK;
      else if (cls == CLS_POLL && off_ff == OFF_NODE) err = ERR_OK;
      else if (cls == CLS_PRES) begin
         if (off_ff < OFF_EVENT) err = ERR_SHORT;
         else if (pl_in != 8'd1) err = ERR_LENGTH;
         else if (event_in != event_attach_ff && event_in != event_detach_ff)
            err = ERR_EVENT;
         else if (!id_ok(src_in)) err = ERR_SRC;
      end else begin
         if (off_ff < OFF_LENGTH) err = ERR_SHORT;
         else if (pl_in > PAYLOAD_LIMIT) err = ERR_OVERSIZE;
         else if (off_ff < OFF_LENGTH + {2'b00, pl_in}) err = ERR_TRUNCATED;
         else if (cls == CLS_DATA && !id_ok(src_in)) err = ERR_SRC;
         else if (cls == CLS_DATA && !id_ok(dst_in)) err = ERR_DST;
      end

      op.has_data = src_stream || dst_stream || payload_stream || event_stream;
      if (src_stream) op.data_kind = KIND_SRC;
      else if (dst_stream) op.data_kind = KIND_DST;
      else op.data_kind = KIND_PAYLOAD;
      op.data_byte   = byte_value;
      op.has_verdict = frame_end;

      op.verdict.result_kind    = KIND_VERDICT;
      op.verdict.data_byte      = 8'd0;
      op.verdict.frame_ok       = (err == ERR_OK);
      op.verdict.error_code     = err;
      op.verdict.packet_class   = known ? cls[1:0] : 2'd0;
      op.verdict.message_id     = msg_in;
      op.verdict.acked_id       = ack_in;
      op.verdict.node_number    = node_in;
      op.verdict.hop_limit      = (known && cls != CLS_ACK) ? hop_in : 8'd0;
      op.verdict.payload_length = (known && cls != CLS_ACK) ? pl_in : 8'd0;
      op.verdict.event_code     = (cls == CLS_PRES) ? event_in : 8'd0;

      op_valid = op.has_data || op.has_verdict;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         code_data_ff     <= 8'd0;
         code_ack_ff      <= 8'd1;
         code_poll_ff     <= 8'd2;
         code_presence_ff <= 8'd3;
         event_attach_ff  <= 8'd65;
         event_detach_ff  <= 8'd68;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            REG_CODE_DATA:     code_data_ff     <= csr_wdata;
            REG_CODE_ACK:      code_ack_ff      <= csr_wdata;
            REG_CODE_POLL:     code_poll_ff     <= csr_wdata;
            REG_CODE_PRESENCE: code_presence_ff <= csr_wdata;
            REG_EVENT_ATTACH:  event_attach_ff  <= csr_wdata;
            REG_EVENT_DETACH:  event_detach_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         off_ff   <= '0;
         class_ff <= CLS_DATA;
         msg_ff   <= 8'd0;
         ack_ff   <= 8'd0;
         node_ff  <= 8'd0;
         hop_ff   <= 8'd0;
         pl_ff    <= 8'd0;
         event_ff <= 8'd0;
         src_ff   <= 3'd0;
         dst_ff   <= 3'd0;
      end else if (accept) begin
         off_ff   <= off_in;
         class_ff <= cls;
         msg_ff   <= msg_in;
         ack_ff   <= ack_in;
         node_ff  <= node_in;
         hop_ff   <= hop_in;
         pl_ff    <= pl_in;
         event_ff <= event_in;
         src_ff   <= src_in;
         dst_ff   <= dst_in;
      end
   end

`include "radio_frame_deserializer_macros.svh"

   `RFD_ASSERT_NEXT(a_frame_restart, accept && frame_end, off_ff == '0, "offset not cleared after last byte")
   `RFD_ASSERT_NOW(a_verdict_on_end, accept && frame_end, op_valid && op.has_verdict, "last byte without verdict")

endmodule

// ===== hdl/rfd_fifo.sv =====
module rfd_fifo
   import rfd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  rfd_op_type push_data,
   input  logic       pop,
   output logic       full,
   output logic       head_valid,
   output rfd_op_type head
);

   rfd_op_type             mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QUEUE_CNT_W-1:0] count_ff;
   logic                   do_push, do_pop;

   assign full       = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head       = mem_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ptr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (do_pop) rd_ptr_ff <= rd_ptr_ff + 1'b1;
         if (do_push && !do_pop) count_ff <= count_ff + 1'b1;
         else if (do_pop && !do_push) count_ff <= count_ff - 1'b1;
      end
   end

`include "radio_frame_deserializer_macros.svh"

   `RFD_ASSERT_NOW(a_count_bound, 1'b1, count_ff <= QUEUE_CNT_W'(QUEUE_DEPTH), "queue count out of range")
   `RFD_ASSERT_NOW(a_no_lost_push, push, !full, "op pushed into a full queue")

endmodule

// ===== hdl/rfd_back.sv =====
module rfd_back
   import rfd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        head_valid,
   input  rfd_op_type  head,
   output logic        pop,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rfd_rsp_type rsp
);

   logic        rsp_valid_ff, rsp_valid_in;
   rfd_rsp_type rsp_ff, rsp_in;
   logic        phase_ff, phase_in;
   logic        load, send_data;

   always_comb begin
      load      = head_valid && (!rsp_valid_ff || rsp_ready);
      // The streamed beat of an op goes out before its verdict.
      send_data = head.has_data && !phase_ff;
      rsp_in    = rsp_ff;
      phase_in  = phase_ff;
      pop       = 1'b0;
      if (load) begin
         if (send_data) begin
            rsp_in             = '0;
            rsp_in.result_kind = head.data_kind;
            rsp_in.data_byte   = head.data_byte;
            phase_in           = head.has_verdict;
            pop                = !head.has_verdict;
         end else begin
            rsp_in   = head.verdict;
            phase_in = 1'b0;
            pop      = 1'b1;
         end
      end
      if (load) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
      else rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         phase_ff     <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         phase_ff     <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

`include "radio_frame_deserializer_macros.svh"

   `RFD_ASSERT_NOW(a_phase_head, phase_ff, head_valid && head.has_data && head.has_verdict, "verdict phase without a pending verdict")

endmodule

// ===== hdl/radio_frame_deserializer.sv =====
// Radio frame parser. Bytes of one frame enter on the req_ channel, one beat
// per byte, with req_frame_end set on the last byte. Results leave on the
// rsp_ channel: source id, destination id and payload bytes as they arrive,
// then one verdict beat (result kind 3) after the last byte carrying the
// first failing check and the header fields.
// A byte is taken every cycle while the queue between the parser front and
// the result stage has room. A byte yields zero, one or two result beats;
// the result stage sends one beat a cycle while rsp_ready is high, so a last
// byte that also streams a byte sends the streamed beat before the verdict.
// With the queue empty and the output free, a byte is parsed into the
// four-entry queue when it is accepted, and the output register then loads
// its result from the queue. When rsp_ready is low, the output register
// holds its beat, the queue fills, and req_ready drops once it is full;
// nothing is lost.
// Reset clears the frame offset, the queue and the output valid and loads
// the default type and event codes. The csr_ port writes one code register
// per enabled cycle; write it between frames only (the block does not check).
module radio_frame_deserializer
   import rfd_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [7:0]             req_byte_value,
   input  logic                   req_frame_end,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [1:0]             rsp_result_kind,
   output logic [7:0]             rsp_data_byte,
   output logic                   rsp_frame_ok,
   output logic [3:0]             rsp_error_code,
   output logic [1:0]             rsp_packet_class,
   output logic [7:0]             rsp_message_id,
   output logic [7:0]             rsp_acked_id,
   output logic [7:0]             rsp_node_number,
   output logic [7:0]             rsp_hop_limit,
   output logic [7:0]             rsp_payload_length,
   output logic [7:0]             rsp_event_code,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [7:0]             csr_wdata
);

   logic        accept, op_valid, full, head_valid, pop;
   rfd_op_type  op, head;
   rfd_rsp_type rsp;

   assign req_ready = !full;
   assign accept    = req_valid && req_ready;

   rfd_front u_front (
      .clock            (clock),
      .reset            (reset),
      .accept           (accept),
      .byte_value       (req_byte_value),
      .frame_end        (req_frame_end),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .op_valid         (op_valid),
      .op               (op)
   );

   rfd_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (accept && op_valid),
      .push_data  (op),
      .pop        (pop),
      .full       (full),
      .head_valid (head_valid),
      .head       (head)
   );

   rfd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp        (rsp)
   );

   assign rsp_result_kind    = rsp.result_kind;
   assign rsp_data_byte      = rsp.data_byte;
   assign rsp_frame_ok       = rsp.frame_ok;
   assign rsp_error_code     = rsp.error_code;
   assign rsp_packet_class   = rsp.packet_class;
   assign rsp_message_id     = rsp.message_id;
   assign rsp_acked_id       = rsp.acked_id;
   assign rsp_node_number    = rsp.node_number;
   assign rsp_hop_limit      = rsp.hop_limit;
   assign rsp_payload_length = rsp.payload_length;
   assign rsp_event_code     = rsp.event_code;

endmodule

// ===== tb/sv/tb_radio_frame_deserializer.sv =====
`timescale 1ns / 100ps

module tb_radio_frame_deserializer;
   import rfd_pkg::*;

   // Index values past the last register; writes to them must change nothing.
   localparam logic [CSR_INDEX_W-1:0] REG_SPARE_LO = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] REG_SPARE_HI = 3'd7;

   localparam int HEADER_LEN    = 4;
   localparam int PRESENCE_LEN  = 23;
   localparam int FULL_HDR_LEN  = 38;
   localparam int DRAIN_CYCLES  = 6;
   localparam int PRINT_LIMIT   = 40;

   typedef enum {ID_DIGITS, ID_FULL, ID_EMPTY, ID_NONDIGIT, ID_NOISE} id_style_type;
   typedef enum {SHAPE_PRESENCE, SHAPE_FULL} frame_shape_type;

   typedef struct packed {
      logic non_digit;
      logic ended;
      logic nonempty;
   } id_track_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [7:0]             req_byte_value = 8'd0;
   logic                   req_frame_end = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [1:0]             rsp_result_kind;
   logic [7:0]             rsp_data_byte;
   logic                   rsp_frame_ok;
   logic [3:0]             rsp_error_code;
   logic [1:0]             rsp_packet_class;
   logic [7:0]             rsp_message_id;
   logic [7:0]             rsp_acked_id;
   logic [7:0]             rsp_node_number;
   logic [7:0]             rsp_hop_limit;
   logic [7:0]             rsp_payload_length;
   logic [7:0]             rsp_event_code;
   logic                   csr_write_enable = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [7:0]             csr_wdata = 8'd0;

   radio_frame_deserializer uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_byte_value     (req_byte_value),
      .req_frame_end      (req_frame_end),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_result_kind    (rsp_result_kind),
      .rsp_data_byte      (rsp_data_byte),
      .rsp_frame_ok       (rsp_frame_ok),
      .rsp_error_code     (rsp_error_code),
      .rsp_packet_class   (rsp_packet_class),
      .rsp_message_id     (rsp_message_id),
      .rsp_acked_id       (rsp_acked_id),
      .rsp_node_number    (rsp_node_number),
      .rsp_hop_limit      (rsp_hop_limit),
      .rsp_payload_length (rsp_payload_length),
      .rsp_event_code     (rsp_event_code),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   // Shadow of the code registers, indexed like the write port.
   logic [7:0] code_shadow [8] = '{8'd0, 8'd1, 8'd2, 8'd3, 8'd65, 8'd68, 8'd0, 8'd0};

   // Parser state as the block should hold it.
   logic [OFF_W-1:0] frame_pos = '0;
   logic [2:0]       frame_cls = CLS_DATA;
   logic [7:0]       hdr_bytes [6] = '{default: 8'd0};
   logic [7:0]       evt_byte = 8'd0;
   id_track_type     src_track = '0;
   id_track_type     dst_track = '0;

   rfd_rsp_type expected_beats [$];
   logic [7:0]  frame_q [$];

   bit idle_on = 1'b1;
   int errors = 0;
   int beats_checked = 0;
   int bytes_sent = 0;
   int frames_sent = 0;
   int frames_ok = 0;
   int err_hits [9] = '{default: 0};

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("tb_radio_frame_deserializer: errors");
      $finish;
   end

   // Result side stalls in random bursts while idling is enabled.
   initial begin : rsp_stall
      int n;
      forever begin
         @(posedge clock);
         if (idle_on && $urandom_range(0, 7) == 0) begin
            n = $urandom_range(1, 13);
            rsp_ready <= 1'b0;
            repeat (n) @(posedge clock);
         end
         rsp_ready <= 1'b1;
      end
   end

   function automatic id_track_type track_id(input id_track_type t, input logic first,
                                             input logic [7:0] b);
      id_track_type n;
      n = t;
      if (!t.ended) begin
         if (b == 8'd0) begin
            n.ended = 1'b1;
         end else begin
            if (b < "0" || b > "9") n.non_digit = 1'b1;
            if (first) n.nonempty = 1'b1;
         end
      end
      return n;
   endfunction

   function automatic logic id_valid(input id_track_type t);
      return t.nonempty && !t.non_digit;
   endfunction

   task automatic push_stream(input logic [1:0] kind, input logic [7:0] b);
      rfd_rsp_type r;
      r = '0;
      r.result_kind = kind;
      r.data_byte = b;
      expected_beats.push_back(r);
   endtask

   // Advances the parser by one accepted byte and queues the beats it yields.
   task automatic parse_byte(input logic [7:0] b, input logic is_last);
      logic [OFF_W-1:0] off;
      logic [2:0]       cls;
      logic [7:0]       pl;
      logic [3:0]       err;
      logic             known;
      int               len;
      rfd_rsp_type      v;
      off = frame_pos;
      if (off == '0) begin
         foreach (hdr_bytes[i]) hdr_bytes[i] = 8'd0;
         evt_byte = 8'd0;
         src_track = '0;
         dst_track = '0;
         if (b == code_shadow[REG_CODE_DATA]) frame_cls = CLS_DATA;
         else if (b == code_shadow[REG_CODE_ACK]) frame_cls = CLS_ACK;
         else if (b == code_shadow[REG_CODE_POLL]) frame_cls = CLS_POLL;
         else if (b == code_shadow[REG_CODE_PRESENCE]) frame_cls = CLS_PRES;
         else frame_cls = CLS_NONE;
      end
      if (off < OFF_SRC_FIRST) hdr_bytes[off[2:0]] = b;
      cls = frame_cls;
      pl = hdr_bytes[5];

      if (cls != CLS_ACK && cls != CLS_NONE && off >= OFF_SRC_FIRST && off < OFF_SRC_END)
      begin
         src_track = track_id(src_track, off == OFF_SRC_FIRST, b);
         push_stream(KIND_SRC, b);
      end
      if (cls == CLS_DATA || cls == CLS_POLL) begin
         if (off >= OFF_DST_FIRST && off < OFF_DST_END) begin
            dst_track = track_id(dst_track, off == OFF_DST_FIRST, b);
            push_stream(KIND_DST, b);
         end else if (off == OFF_LENGTH) begin
            hdr_bytes[5] = b;
         end else if (off >= OFF_PAYLOAD && pl <= PAYLOAD_LIMIT
                      && int'(off) < int'(OFF_PAYLOAD) + int'(pl)) begin
            push_stream(KIND_PAYLOAD, b);
         end
      end else if (cls == CLS_PRES) begin
         if (off == OFF_PRES_LEN) begin
            hdr_bytes[5] = b;
         end else if (off == OFF_EVENT) begin
            evt_byte = b;
            push_stream(KIND_PAYLOAD, b);
         end
      end

      if (frame_pos != OFF_MAX) frame_pos = frame_pos + 1'b1;

      if (is_last) begin
         len = int'(off) + 1;
         pl = hdr_bytes[5];
         known = (cls != CLS_NONE);
         err = ERR_OK;
         if (len < HEADER_LEN) err = ERR_SHORT;
         else if (!known) err = ERR_TYPE;
         else if (cls == CLS_ACK) err = ERR_OK;
         else if (cls == CLS_POLL && len == HEADER_LEN) err = ERR_OK;
         else if (cls == CLS_PRES) begin
            if (len < PRESENCE_LEN) err = ERR_SHORT;
            else if (pl != 8'd1) err = ERR_LENGTH;
            else if (evt_byte != code_shadow[REG_EVENT_ATTACH]
                     && evt_byte != code_shadow[REG_EVENT_DETACH]) err = ERR_EVENT;
            else if (!id_valid(src_track)) err = ERR_SRC;
         end else begin
            if (len < FULL_HDR_LEN) err = ERR_SHORT;
            else if (pl > PAYLOAD_LIMIT) err = ERR_OVERSIZE;
            else if (len < FULL_HDR_LEN + int'(pl)) err = ERR_TRUNCATED;
            else if (cls == CLS_DATA && !id_valid(src_track)) err = ERR_SRC;
            else if (cls == CLS_DATA && !id_valid(dst_track)) err = ERR_DST;
         end

         v = '0;
         v.result_kind = KIND_VERDICT;
         v.frame_ok = (err == ERR_OK);
         v.error_code = err;
         v.packet_class = known ? cls[1:0] : 2'd0;
         v.message_id = hdr_bytes[1];
         v.acked_id = hdr_bytes[2];
         v.node_number = hdr_bytes[3];
         v.hop_limit = (known && cls != CLS_ACK) ? hdr_bytes[4] : 8'd0;
         v.payload_length = (known && cls != CLS_ACK) ? pl : 8'd0;
         v.event_code = (cls == CLS_PRES) ? evt_byte : 8'd0;
         expected_beats.push_back(v);
         err_hits[err]++;
         if (err == ERR_OK) frames_ok++;
         frame_pos = '0;
      end
   endtask

   task automatic report_mismatch(input string what, input int got, input int want);
      errors++;
      if (errors <= PRINT_LIMIT)
         $display("%0t ns: beat %0d %s: got 0x%0h, expected 0x%0h",
                  $time, beats_checked, what, got, want);
   endtask

   always @(posedge clock) begin : check_rsp
      rfd_rsp_type got;
      rfd_rsp_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         got = {rsp_result_kind, rsp_data_byte, rsp_frame_ok, rsp_error_code,
                rsp_packet_class, rsp_message_id, rsp_acked_id, rsp_node_number,
                rsp_hop_limit, rsp_payload_length, rsp_event_code};
         if (expected_beats.size() == 0) begin
            report_mismatch("arrived with nothing pending, kind", got.result_kind, 0);
         end else begin
            want = expected_beats.pop_front();
            if (got.result_kind !== want.result_kind)
               report_mismatch("result_kind", got.result_kind, want.result_kind);
            if (got.data_byte !== want.data_byte)
               report_mismatch("data_byte", got.data_byte, want.data_byte);
            if (got.frame_ok !== want.frame_ok)
               report_mismatch("frame_ok", got.frame_ok, want.frame_ok);
            if (got.error_code !== want.error_code)
               report_mismatch("error_code", got.error_code, want.error_code);
            if (got.packet_class !== want.packet_class)
               report_mismatch("packet_class", got.packet_class, want.packet_class);
            if (got.message_id !== want.message_id)
               report_mismatch("message_id", got.message_id, want.message_id);
            if (got.acked_id !== want.acked_id)
               report_mismatch("acked_id", got.acked_id, want.acked_id);
            if (got.node_number !== want.node_number)
               report_mismatch("node_number", got.node_number, want.node_number);
            if (got.hop_limit !== want.hop_limit)
               report_mismatch("hop_limit", got.hop_limit, want.hop_limit);
            if (got.payload_length !== want.payload_length)
               report_mismatch("payload_length", got.payload_length, want.payload_length);
            if (got.event_code !== want.event_code)
               report_mismatch("event_code", got.event_code, want.event_code);
         end
         beats_checked++;
      end
   end

   // Valid stays high from one beat to the next unless a gap is inserted.
   task automatic send_byte(input logic [7:0] b, input logic is_last);
      if (idle_on && $urandom_range(0, 9) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_byte_value <= b;
      req_frame_end <= is_last;
      do @(posedge clock); while (req_ready !== 1'b1);
      parse_byte(b, is_last);
      bytes_sent++;
   endtask

   task automatic wait_drain();
      req_valid <= 1'b0;
      while (expected_beats.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx, input logic [7:0] val);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      code_shadow[idx] = val;
   endtask

   task automatic load_codes(input logic [7:0] d, input logic [7:0] a, input logic [7:0] p,
                             input logic [7:0] pr, input logic [7:0] ea,
                             input logic [7:0] ed);
      wait_drain();
      write_csr(REG_CODE_DATA, d);
      write_csr(REG_CODE_ACK, a);
      write_csr(REG_CODE_POLL, p);
      write_csr(REG_CODE_PRESENCE, pr);
      write_csr(REG_EVENT_ATTACH, ea);
      write_csr(REG_EVENT_DETACH, ed);
      write_csr(REG_SPARE_LO, 8'($urandom));
      write_csr(REG_SPARE_HI, 8'($urandom));
      csr_write_enable <= 1'b0;
   endtask

   function automatic logic [7:0] rand_digit();
      return 8'h30 + 8'($urandom_range(0, 9));
   endfunction

   function automatic id_style_type rand_id_style();
      if ($urandom_range(0, 9) < 7) return $urandom_range(0, 1) ? ID_FULL : ID_DIGITS;
      return id_style_type'($urandom_range(2, 4));
   endfunction

   // Appends the 16 bytes of an id field; the 16th is never checked.
   task automatic append_id(input id_style_type style);
      int n;
      int bad;
      int k;
      logic [7:0] b;
      n = $urandom_range(1, 15);
      bad = $urandom_range(0, n - 1);
      for (k = 0; k < 16; k++) begin
         b = 8'($urandom);
         case (style)
            ID_DIGITS: if (k < n) b = rand_digit(); else if (k == n) b = 8'd0;
            ID_FULL: if (k < 15) b = rand_digit();
            ID_EMPTY: if (k == 0) b = 8'd0;
            ID_NONDIGIT: begin
               if (k == bad)
                  b = $urandom_range(0, 1) ? 8'($urandom_range(1, 8'h2f))
                                           : 8'($urandom_range(8'h3a, 8'hff));
               else if (k < n) b = rand_digit();
               else if (k == n) b = 8'd0;
            end
            default: ;
         endcase
         frame_q.push_back(b);
      end
   endtask

   // Builds a frame laid out for the shape, cut or padded to total bytes when
   // total is nonzero, and sends it.
   task automatic send_frame(input frame_shape_type shape, input logic [7:0] type_code,
                             input logic [7:0] len_byte, input logic [7:0] evt,
                             input id_style_type src, input id_style_type dst,
                             input int total);
      int k;
      frame_q.delete();
      frame_q.push_back(type_code);
      for (k = 1; k <= int'(OFF_HOP); k++) frame_q.push_back(8'($urandom));
      append_id(src);
      if (shape == SHAPE_PRESENCE) begin
         frame_q.push_back(len_byte);
         frame_q.push_back(evt);
      end else begin
         append_id(dst);
         frame_q.push_back(len_byte);
         for (k = 0; k < int'(len_byte); k++) frame_q.push_back(8'($urandom));
      end
      if (total > 0) begin
         while (frame_q.size() > total) void'(frame_q.pop_back());
         while (frame_q.size() < total) frame_q.push_back(8'($urandom));
      end
      for (k = 0; k < frame_q.size(); k++) send_byte(frame_q[k], k == frame_q.size() - 1);
      frames_sent++;
   endtask

   task automatic test_short_and_header_frames();
      send_frame(SHAPE_FULL, code_shadow[REG_CODE_DATA], 8'd0, 8'd0, ID_DIGITS, ID_DIGITS, 1);
      send_frame(SHAPE_FULL, 8'hff, 8'd0, 8'd0, ID_NOISE, ID_NOISE, 3);
      send_frame(SHAPE_FULL, 8'hff, 8'd0, 8'd0, ID_NOISE, ID_NOISE, HEADER_LEN);
      send_frame(SHAPE_FULL, code_shadow[REG_CODE_ACK], 8'd0, 8'd0, ID_NOISE, ID_NOISE, 2);
      send_frame(SHAPE_FULL, code_shadow[REG_CODE_ACK], 8'd0, 8'd0, ID_NOISE, ID_NOISE,
                 HEADER_LEN);
      // An ack with a full body streams nothing and is still accepted.
      send_frame(SHAPE_FULL, code_shadow[REG_CODE_ACK], 8'd5, 8'd0, ID_NOISE, ID_NOISE, 0);
      send_frame(SHAPE_FULL, code_shadow[REG_CODE_POLL], 8'd0, 8'd0, ID_NOISE, ID_NOISE,
                 HEADER_LEN);
      send_frame(SHAPE_FULL, code_shadow[REG_CODE_POLL], 8'd0, 8'd0, ID_NOISE, ID_NOISE,
                 HEADER_LEN + 1);
   endtask

   task automatic test_presence_checks();
      logic [7:0] pres;
      logic [7:0] att;
      logic [7:0] det;
      pres = code_shadow[REG_CODE_PRESENCE];
      att = code_shadow[REG_EVENT_ATTACH];
      det = code_shadow[REG_EVENT_DETACH];
      send_frame(SHAPE_PRESENCE, pres, 8'd1, att, ID_DIGITS, ID_NOISE, 0);
      send_frame(SHAPE_PRESENCE, pres, 8'd1, det, ID_FULL, ID_NOISE, PRESENCE_LEN + 5);
      send_frame(SHAPE_PRESENCE, pres, 8'd0, att, ID_DIGITS, ID_NOISE, 0);
      send_frame(SHAPE_PRESENCE, pres, 8'hff, att, ID_DIGITS, ID_NOISE, 0);
      send_frame(SHAPE_PRESENCE, pres, 8'd1, 8'd0, ID_DIGITS, ID_NOISE, 0);
      send_frame(SHAPE_PRESENCE, pres, 8'd1, det, ID_EMPTY, ID_NOISE, 0);
      send_frame(SHAPE_PRESENCE, pres, 8'd1, att, ID_NONDIGIT, ID_NOISE, 0);
      send_frame(SHAPE_PRESENCE, pres, 8'd1, att, ID_DIGITS, ID_NOISE, PRESENCE_LEN - 1);
   endtask

   task automatic test_data_checks();
      logic [7:0] dat;
      dat = code_shadow[REG_CODE_DATA];
      send_frame(SHAPE_FULL, dat, 8'd0, 8'd0, ID_DIGITS, ID_DIGITS, 0);
      send_frame(SHAPE_FULL, dat, PAYLOAD_LIMIT, 8'd0, ID_FULL, ID_FULL, 0);
      send_frame(SHAPE_FULL, dat, PAYLOAD_LIMIT + 8'd1, 8'd0, ID_DIGITS, ID_DIGITS,
                 FULL_HDR_LEN + 2);
      send_frame(SHAPE_FULL, dat, 8'hff, 8'd0, ID_DIGITS, ID_DIGITS, FULL_HDR_LEN);
      send_frame(SHAPE_FULL, dat, 8'd10, 8'd0, ID_DIGITS, ID_DIGITS, FULL_HDR_LEN + 7);
      send_frame(SHAPE_FULL, dat, 8'd4, 8'd0, ID_EMPTY, ID_DIGITS, 0);
      send_frame(SHAPE_FULL, dat, 8'd4, 8'd0, ID_FULL, ID_NONDIGIT, 0);
      send_frame(SHAPE_FULL, dat, 8'd4, 8'd0, ID_DIGITS, ID_DIGITS, FULL_HDR_LEN - 1);
      // A long poll ignores both ids.
      send_frame(SHAPE_FULL, code_shadow[REG_CODE_POLL], 8'd3, 8'd0, ID_NOISE, ID_EMPTY, 0);
   endtask

   task automatic test_code_priority();
      load_codes(8'hff, 8'hff, 8'hff, 8'hff, 8'd0, 8'hff);
      send_frame(SHAPE_FULL, 8'hff, 8'd2, 8'd0, ID_DIGITS, ID_DIGITS, 0);
      load_codes(8'h20, 8'h10, 8'h10, 8'h10, 8'd0, 8'hff);
      send_frame(SHAPE_FULL, 8'h10, 8'd2, 8'd0, ID_DIGITS, ID_DIGITS, HEADER_LEN);
      load_codes(8'h20, 8'h30, 8'h07, 8'h07, 8'd0, 8'hff);
      send_frame(SHAPE_FULL, 8'h07, 8'd2, 8'd0, ID_DIGITS, ID_DIGITS, HEADER_LEN);
      load_codes(8'h40, 8'h41, 8'h42, 8'h43, 8'd0, 8'hff);
      send_frame(SHAPE_PRESENCE, 8'h43, 8'd1, 8'd0, ID_FULL, ID_NOISE, 0);
      send_frame(SHAPE_PRESENCE, 8'h43, 8'd1, 8'hff, ID_DIGITS, ID_NOISE, 0);
      send_frame(SHAPE_PRESENCE, 8'h43, 8'd1, 8'd1, ID_DIGITS, ID_NOISE, 0);
   endtask

   task automatic send_random_frame();
      int pick;
      int total;
      logic [7:0] pl;
      logic [7:0] evt;
      pick = $urandom_range(0, 99);
      pl = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 24));
      evt = $urandom_range(0, 1) ? code_shadow[REG_EVENT_ATTACH]
                                 : code_shadow[REG_EVENT_DETACH];
      if ($urandom_range(0, 7) == 0) evt = 8'($urandom);
      total = ($urandom_range(0, 6) == 0) ? $urandom_range(1, 60) : 0;
      if (pick < 35)
         send_frame(SHAPE_FULL, code_shadow[REG_CODE_DATA], pl, evt, rand_id_style(),
                    rand_id_style(), total);
      else if (pick < 50)
         send_frame(SHAPE_FULL, code_shadow[REG_CODE_POLL], pl, evt, rand_id_style(),
                    rand_id_style(), $urandom_range(0, 1) ? HEADER_LEN : total);
      else if (pick < 70)
         send_frame(SHAPE_PRESENCE, code_shadow[REG_CODE_PRESENCE],
                    ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'd1, evt,
                    rand_id_style(), ID_NOISE, total);
      else if (pick < 80)
         send_frame(SHAPE_FULL, code_shadow[REG_CODE_ACK], pl, evt, ID_NOISE, ID_NOISE,
                    $urandom_range(1, 30));
      else
         send_frame(SHAPE_FULL, 8'($urandom), pl, evt, ID_NOISE, ID_NOISE,
                    $urandom_range(1, 45));
   endtask

   task automatic test_random_frames(input int count, input bit with_idling);
      int k;
      idle_on = with_idling;
      for (k = 0; k < count; k++) begin
         // Now and then the sender holds off until the block has emptied.
         if (k % 3 == 2) wait_drain();
         send_random_frame();
      end
   endtask

   initial begin : main
      string per_code;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      test_short_and_header_frames();
      test_presence_checks();
      test_data_checks();
      test_code_priority();

      load_codes(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                 8'($urandom), 8'($urandom));
      test_random_frames(3, 1'b1);
      load_codes(8'd0, 8'hff, 8'h55, 8'haa, 8'hff, 8'd0);
      test_random_frames(2, 1'b0);
      load_codes(8'd9, 8'd9, 8'd200, 8'd201, 8'd65, 8'd65);
      test_random_frames(3, 1'b1);
      load_codes(8'd0, 8'd1, 8'd2, 8'd3, 8'd65, 8'd68);
      test_random_frames(2, 1'b0);

      wait_drain();
      per_code = "";
      foreach (err_hits[i]) per_code = {per_code, $sformatf(" %0d", err_hits[i])};
      $display("Sent %0d frames (%0d bytes, %0d accepted); %0d result beats compared.",
               frames_sent, bytes_sent, frames_ok, beats_checked);
      $display("Verdicts per error code, ok through truncated:%s", per_code);
      if (errors == 0) begin
         $display("tb_radio_frame_deserializer: clean");
      end else begin
         $display("tb_radio_frame_deserializer: errors");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/rfd_pkg.sv
hdl/rfd_front.sv
hdl/rfd_fifo.sv
hdl/rfd_back.sv
hdl/radio_frame_deserializer.sv
tb/sv/tb_radio_frame_deserializer.sv
